FILE: hw/rtl/delimited_frame_length_checker_top_defines.svh
// ----------------------------------------------------------------------------
// Delimited frame length checker: assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_LENGTH_CHECKER_TOP_DEFINES_SVH
`define DELIMITED_FRAME_LENGTH_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTH
`define DFLC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dflc assertion failed");
`define DFLC_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("dflc reset assertion failed");
`else
`define DFLC_ASSERT_IMPL(label, ante, cons)
`define DFLC_ASSERT_AFTER_RESET(label, cons)
`endif

`endif

FILE: hw/rtl/dflc_pkg.sv
// ----------------------------------------------------------------------------
// dflc_pkg
// Shared types, codes and character constants of the frame length checker.
// ----------------------------------------------------------------------------
package dflc_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_M     = 8'h6D;

  localparam int unsigned KEY_LEN     = 7;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_MISMATCH = 2'd2
  } frame_status_t;

  typedef enum logic [1:0] {
    NUM_SKIP   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  // One committed group: up to three held delimiter bytes, then an optional byte.
  typedef struct packed {
    logic       end_frame;
    logic [1:0] ws_cnt;
    logic       has_c;
    logic [7:0] data;
  } rec_t;

  function automatic logic [7:0] delim_char(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h6D;
      3'd1:    ch = 8'h73;
      3'd2:    ch = 8'h67;
      3'd3:    ch = 8'h5F;
      3'd4:    ch = 8'h6C;
      3'd5:    ch = 8'h65;
      3'd6:    ch = 8'h6E;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: hw/rtl/delimited_frame_length_checker_top.sv
// ----------------------------------------------------------------------------
// delimited_frame_length_checker_top
// A frame result is registered once its closing LF has left the work queue.
// Throughput: one byte per cycle while in_full is low; each byte passes the
// delimiter matcher and the header scanner, with a four-entry queue between.
// Reset: synchronous, clears the matcher, queue, scanner and out_valid flag.
// ----------------------------------------------------------------------------
`include "delimited_frame_length_checker_top_defines.svh"

module delimited_frame_length_checker_top #(
  parameter int unsigned HEADER_WINDOW = 29,
  parameter int unsigned LENGTH_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_data_byte,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [15:0] out_frame_length,
  output logic [15:0] out_declared_length,
  output logic [1:0]  out_frame_status
);
  import dflc_pkg::*;

  rec_t front_rec;
  rec_t head_rec;
  logic front_push;
  logic q_full;
  logic q_empty;
  logic q_pop;

  dflc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_full      (in_full),
    .q_push       (front_push),
    .q_rec        (front_rec),
    .q_full       (q_full)
  );

  dflc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_rec (front_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head_rec (head_rec),
    .empty    (q_empty)
  );

  dflc_back #(
    .HEADER_WINDOW (HEADER_WINDOW),
    .LENGTH_WIDTH  (LENGTH_WIDTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_rec               (head_rec),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_frame_length    (out_frame_length),
    .out_declared_length (out_declared_length),
    .out_frame_status    (out_frame_status)
  );

  `DFLC_ASSERT_IMPL(a_ok_lengths_equal, !out_empty && (out_frame_status == ST_OK), out_frame_length == out_declared_length)
  `DFLC_ASSERT_IMPL(a_missing_has_zero, !out_empty && (out_frame_status == ST_MISSING), out_declared_length == 16'd0)
  `DFLC_ASSERT_AFTER_RESET(a_reset_empty, out_empty)

endmodule

FILE: hw/rtl/dflc_front.sv
// ----------------------------------------------------------------------------
// dflc_front
// Delimiter matcher: holds back possible CR LF CR LF bytes and emits
// committed byte groups or a frame end into the work queue.
// ----------------------------------------------------------------------------
module dflc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic [7:0]    in_data_byte,
  output logic          in_full,
  output logic          q_push,
  output dflc_pkg::rec_t q_rec,
  input  logic          q_full
);
  import dflc_pkg::*;

  logic [1:0] prog_r, prog_nxt;
  logic       accept;
  logic [2:0] q_val;
  logic [2:0] n_val;
  logic       end_frame;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    if (in_data_byte == delim_char(prog_r)) begin
      q_val = {1'b0, prog_r} + 3'd1;
    end else if (in_data_byte == CHAR_CR) begin
      q_val = 3'd1;
    end else begin
      q_val = 3'd0;
    end
    end_frame = (q_val == 3'd4);
    n_val     = {1'b0, prog_r} + 3'd1 - q_val;

    q_rec.end_frame = end_frame;
    q_rec.has_c     = (q_val == 3'd0);
    q_rec.ws_cnt    = (q_val == 3'd0) ? prog_r : n_val[1:0];
    q_rec.data      = in_data_byte;

    q_push   = accept && (end_frame || q_rec.has_c || (q_rec.ws_cnt != 2'd0));
    prog_nxt = prog_r;
    if (accept) begin
      prog_nxt = end_frame ? 2'd0 : q_val[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_r <= 2'd0;
    end else begin
      prog_r <= prog_nxt;
    end
  end

endmodule

FILE: hw/rtl/dflc_queue.sv
// ----------------------------------------------------------------------------
// dflc_queue
// Short first-in first-out queue of work records between front and back.
// ----------------------------------------------------------------------------
module dflc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dflc_pkg::rec_t push_rec,
  output logic           full,
  input  logic           pop,
  output dflc_pkg::rec_t head_rec,
  output logic           empty
);
  import dflc_pkg::*;

  rec_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_rec = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/dflc_back.sv
// ----------------------------------------------------------------------------
// dflc_back
// Header scanner and frame checker: tokenises the header window, parses the
// declared length and registers one result per completed frame.
// ----------------------------------------------------------------------------
module dflc_back #(
  parameter int unsigned HEADER_WINDOW = 29,
  parameter int unsigned LENGTH_WIDTH  = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  dflc_pkg::rec_t q_rec,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           out_pop,
  output logic           out_empty,
  output logic [15:0]    out_frame_length,
  output logic [15:0]    out_declared_length,
  output logic [1:0]     out_frame_status
);
  import dflc_pkg::*;

  localparam int unsigned LW = LENGTH_WIDTH;
  localparam int unsigned WW = $clog2(HEADER_WINDOW + 1);
  localparam logic [WW-1:0]   WIN_FULL = WW'(HEADER_WINDOW);
  localparam logic [WW+1:0]   WIN_FULL_X = (WW + 2)'(HEADER_WINDOW);
  localparam logic [LW-1:0]   LEN_MAX = {LW{1'b1}};

  typedef struct packed {
    logic [2:0]    key_prog;
    logic          tok_has_key;
    logic          key_seen;
    num_phase_t    num_phase;
    logic          num_neg;
    logic [LW-1:0] num_val;
    logic          len_cap;
    logic          tok_open;
    logic [WW-1:0] win;
  } scan_t;

  function automatic scan_t clear_token(input scan_t s);
    scan_t t;
    t             = s;
    t.tok_open    = 1'b0;
    t.key_prog    = 3'd0;
    t.tok_has_key = 1'b0;
    t.num_phase   = NUM_SKIP;
    t.num_neg     = 1'b0;
    t.num_val     = '0;
    return t;
  endfunction

  function automatic scan_t finish_token(input scan_t s);
    scan_t t;
    t = s;
    if (s.tok_open && !s.len_cap) begin
      if (s.tok_has_key) begin
        t.key_seen = 1'b1;
        t          = clear_token(t);
      end else if (s.key_seen) begin
        t.len_cap  = 1'b1;
        t.tok_open = 1'b0;
      end else begin
        t = clear_token(t);
      end
    end
    return t;
  endfunction

  function automatic scan_t token_char(input scan_t s, input logic [7:0] c);
    scan_t         t;
    logic          is_digit;
    logic          is_space;
    logic [3:0]    dig;
    logic [LW+3:0] ext;
    logic [LW+3:0] prod;
    t        = s;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    dig      = 4'(c - CHAR_ZERO);
    ext      = (LW + 4)'(s.num_val);
    prod     = (ext << 3) + (ext << 1) + (LW + 4)'(dig);
    if (!s.len_cap) begin
      t.tok_open = 1'b1;
      if (!s.tok_has_key) begin
        if ((s.key_prog < 3'(KEY_LEN)) && (c == key_char(s.key_prog))) begin
          if (s.key_prog == 3'(KEY_LEN - 1)) begin
            t.tok_has_key = 1'b1;
            t.key_prog    = 3'd0;
          end else begin
            t.key_prog = s.key_prog + 3'd1;
          end
        end else begin
          t.key_prog = (c == CHAR_M) ? 3'd1 : 3'd0;
        end
      end
      case (s.num_phase)
        NUM_SKIP: begin
          if (is_space) begin
            t.num_phase = NUM_SKIP;
          end else if (c == CHAR_PLUS) begin
            t.num_phase = NUM_DIGITS;
          end else if (c == CHAR_MINUS) begin
            t.num_neg   = 1'b1;
            t.num_phase = NUM_DIGITS;
          end else if (is_digit) begin
            t.num_val   = LW'(dig);
            t.num_phase = NUM_DIGITS;
          end else begin
            t.num_phase = NUM_DONE;
          end
        end
        NUM_DIGITS: begin
          if (is_digit) begin
            t.num_val = (|prod[LW+3:LW]) ? LEN_MAX : prod[LW-1:0];
          end else begin
            t.num_phase = NUM_DONE;
          end
        end
        default: begin
          t.num_phase = s.num_phase;
        end
      endcase
    end
    return t;
  endfunction

  function automatic scan_t scan_byte(input scan_t s, input logic [7:0] c);
    scan_t t;
    t = s;
    if (s.win < WIN_FULL) begin
      if (c == CHAR_NUL) begin
        t     = finish_token(s);
        t.win = WIN_FULL;
      end else begin
        t.win = s.win + 1'b1;
        if ((c == CHAR_COMMA) || (c == CHAR_COLON)) begin
          t = finish_token(t);
        end else begin
          t = token_char(t, c);
        end
        if (t.win == WIN_FULL) begin
          t = finish_token(t);
        end
      end
    end
    return t;
  endfunction

  // Held delimiter bytes are all whitespace: one token step, window advances by k.
  function automatic scan_t scan_ws(input scan_t s, input logic [1:0] k);
    scan_t         t;
    logic [WW+1:0] sum;
    t   = s;
    sum = (WW + 2)'(s.win) + (WW + 2)'(k);
    if (s.win < WIN_FULL) begin
      t = token_char(s, CHAR_CR);
      if (sum >= WIN_FULL_X) begin
        t.win = WIN_FULL;
        t     = finish_token(t);
      end else begin
        t.win = sum[WW-1:0];
      end
    end
    return t;
  endfunction

  scan_t         scan_r, scan_nxt;
  scan_t         s_ws, s_byte, s_fin;
  logic [LW-1:0] bcnt_r, bcnt_nxt;
  logic [LW:0]   bsum;
  logic [LW-1:0] bsat;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   flen_r, flen_nxt;
  logic [15:0]   dlen_r, dlen_nxt;
  frame_status_t status_r, status_nxt;
  frame_status_t status_c;
  logic [LW-1:0] dlen_c;
  logic          out_free;
  logic          out_take;

  assign out_take            = out_pop && out_valid_r;
  assign out_free            = !out_valid_r || out_take;
  assign q_pop               = !q_empty && (!q_rec.end_frame || out_free);
  assign out_empty           = !out_valid_r;
  assign out_frame_length    = flen_r;
  assign out_declared_length = dlen_r;
  assign out_frame_status    = status_r;

  always_comb begin
    s_ws   = (q_rec.ws_cnt != 2'd0) ? scan_ws(scan_r, q_rec.ws_cnt) : scan_r;
    s_byte = q_rec.has_c ? scan_byte(s_ws, q_rec.data) : s_ws;
    bsum   = (LW + 1)'(bcnt_r) + (LW + 1)'(q_rec.ws_cnt) + (LW + 1)'(q_rec.has_c);
    bsat   = (bsum > (LW + 1)'(LEN_MAX)) ? LEN_MAX : bsum[LW-1:0];

    s_fin  = finish_token(scan_r);
    dlen_c = s_fin.len_cap ? s_fin.num_val : '0;
    priority if (!s_fin.len_cap || (s_fin.num_val == '0)) begin
      status_c = ST_MISSING;
    end else if (s_fin.num_neg) begin
      status_c = ST_MISMATCH;
    end else if (s_fin.num_val == bcnt_r) begin
      status_c = ST_OK;
    end else begin
      status_c = ST_MISMATCH;
    end

    scan_nxt      = scan_r;
    bcnt_nxt      = bcnt_r;
    flen_nxt      = flen_r;
    dlen_nxt      = dlen_r;
    status_nxt    = status_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    if (q_pop) begin
      if (q_rec.end_frame) begin
        scan_nxt      = scan_t'('0);
        bcnt_nxt      = '0;
        flen_nxt      = 16'(bcnt_r);
        dlen_nxt      = 16'(dlen_c);
        status_nxt    = status_c;
        out_valid_nxt = 1'b1;
      end else begin
        scan_nxt = s_byte;
        bcnt_nxt = bsat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= scan_t'('0);
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      scan_r      <= scan_nxt;
      bcnt_r      <= bcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flen_r   <= flen_nxt;
    dlen_r   <= dlen_nxt;
    status_r <= status_nxt;
  end

endmodule

FILE: tb/delimited_frame_length_checker_top_tb.sv
// ----------------------------------------------------------------------------
// delimited_frame_length_checker_top_tb
// Drives a byte stream of delimited frames into the checker: a table of
// directed frames first, then randomised frames, keyed, keyless or pure
// noise. A predictor tracks each accepted byte and queues the frame results;
// every popped transaction is compared field by field with the oldest queued
// result. Both sides idle at random, and a watchdog ends a run that stops
// moving.
// ----------------------------------------------------------------------------
module delimited_frame_length_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dflc_pkg::*;

  localparam int unsigned HDR_WINDOW   = 29;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned LEN_MAX      = (1 << LEN_W) - 1;
  localparam int          RANDOM_BYTES = 850;
  localparam int          IDLE_LIMIT   = 1000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          DIR_ROWS     = 15;
  localparam string       KEY_TEXT     = "msg_len";
  localparam logic [7:0]  DELIM [4]    = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};
  // stands for a NUL byte in the directed table
  localparam logic [7:0]  NUL_MARK     = 8'h01;

  typedef struct {
    logic [15:0]   frame_length;
    logic [15:0]   declared_length;
    frame_status_t status;
  } frame_rec_t;

  typedef struct {
    logic [7:0] data;
    bit         typed;
    frame_rec_t res;
  } stim_byte_t;

  typedef struct {
    string         text;
    bit            typed;
    logic [15:0]   flen;
    logic [15:0]   dlen;
    frame_status_t st;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_full;
  logic        out_pop = 1'b0;
  logic        out_empty;
  logic [15:0] out_frame_length;
  logic [15:0] out_declared_length;
  logic [1:0]  out_frame_status;

  logic        running = 1'b0;
  stim_byte_t  stim_q [$];
  frame_rec_t  pending_frames [$];
  int          sent = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          pop_hold = 0;
  logic [15:0] pop_pattern = 16'hFFFF;

  logic [1:0]  delim_seen;
  logic [15:0] frame_bytes;
  int unsigned hdr_count;
  int unsigned key_prog;
  bit          tok_key;
  bit          key_found;
  bit          tok_open;
  bit          num_neg;
  bit          captured;
  num_phase_t  num_state;
  logic [15:0] num_mag;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{"",                                   1'b1, 16'd0,  16'd0,     ST_MISSING},
    '{"msg_len:9",                          1'b1, 16'd9,  16'd9,     ST_OK},
    '{"msg_len:-5",                         1'b1, 16'd10, 16'd5,     ST_MISMATCH},
    '{"msg_len:+",                          1'b1, 16'd9,  16'd0,     ST_MISSING},
    '{"msg_len:-0",                         1'b1, 16'd10, 16'd0,     ST_MISSING},
    '{"msg_len:0",                          1'b1, 16'd9,  16'd0,     ST_MISSING},
    '{"msg_len:99999",                      1'b1, 16'd13, 16'd65535, ST_MISMATCH},
    '{"12,34",                              1'b1, 16'd5,  16'd0,     ST_MISSING},
    '{"msg_len\001:5",                      1'b1, 16'd10, 16'd0,     ST_MISSING},
    '{"\377msg_len:12",                     1'b1, 16'd11, 16'd12,    ST_MISMATCH},
    '{"msg_len: 20,aaaaaaaa",               1'b1, 16'd20, 16'd20,    ST_OK},
    '{"::mmsg_len,, +14,x",                 1'b0, 16'd0,  16'd0,     ST_OK},
    '{"msg_len:\015\0127\015",              1'b0, 16'd0,  16'd0,     ST_OK},
    '{"aaaaaaaaaaaaaaaaaa,msg_len:12345",   1'b0, 16'd0,  16'd0,     ST_OK},
    '{"a\015\012\015b,msg_len:\0112",       1'b0, 16'd0,  16'd0,     ST_OK}
  };

  delimited_frame_length_checker_top #(
    .HEADER_WINDOW(HDR_WINDOW),
    .LENGTH_WIDTH (LEN_W)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_data_byte       (in_data_byte),
    .in_full            (in_full),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_frame_length   (out_frame_length),
    .out_declared_length(out_declared_length),
    .out_frame_status   (out_frame_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void clear_token();
    tok_open  = 1'b0;
    key_prog  = 0;
    tok_key   = 1'b0;
    num_state = NUM_SKIP;
    num_neg   = 1'b0;
    num_mag   = '0;
  endfunction

  function automatic void clear_frame();
    delim_seen  = '0;
    frame_bytes = '0;
    hdr_count   = 0;
    key_found   = 1'b0;
    captured    = 1'b0;
    clear_token();
  endfunction

  function automatic void close_token();
    if (!tok_open || captured) return;
    if (tok_key) begin
      key_found = 1'b1;
    end else if (key_found) begin
      captured = 1'b1;
      tok_open = 1'b0;
      return;
    end
    clear_token();
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_NINE;
  endfunction

  function automatic void token_byte(logic [7:0] c);
    int unsigned acc;
    if (captured) return;
    tok_open = 1'b1;
    if (!tok_key) begin
      if (key_prog < KEY_LEN && c == KEY_TEXT[key_prog]) begin
        key_prog++;
        if (key_prog == KEY_LEN) begin
          tok_key  = 1'b1;
          key_prog = 0;
        end
      end else begin
        key_prog = (c == CHAR_M) ? 1 : 0;
      end
    end
    case (num_state)
      NUM_SKIP: begin
        if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
        end else if (c == CHAR_PLUS) begin
          num_state = NUM_DIGITS;
        end else if (c == CHAR_MINUS) begin
          num_neg   = 1'b1;
          num_state = NUM_DIGITS;
        end else if (is_digit(c)) begin
          num_mag   = 16'(c - CHAR_ZERO);
          num_state = NUM_DIGITS;
        end else begin
          num_state = NUM_DONE;
        end
      end
      NUM_DIGITS: begin
        if (is_digit(c)) begin
          acc     = num_mag * 10 + c - CHAR_ZERO;
          num_mag = (acc > LEN_MAX) ? LEN_MAX[15:0] : acc[15:0];
        end else begin
          num_state = NUM_DONE;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void scan_header(logic [7:0] c);
    if (hdr_count >= HDR_WINDOW) return;
    if (c == CHAR_NUL) begin
      close_token();
      hdr_count = HDR_WINDOW;
      return;
    end
    hdr_count++;
    if (c == CHAR_COMMA || c == CHAR_COLON) close_token();
    else token_byte(c);
    if (hdr_count >= HDR_WINDOW) close_token();
  endfunction

  function automatic void commit_byte(logic [7:0] c);
    if (frame_bytes < LEN_MAX) frame_bytes++;
    scan_header(c);
  endfunction

  function automatic bit track_frame_byte(input logic [7:0] c, output frame_rec_t res);
    int p;
    int q;
    p = int'(delim_seen);
    if (c == DELIM[p]) q = p + 1;
    else if (c == CHAR_CR) q = 1;
    else q = 0;
    if (q == 4) begin
      close_token();
      res.frame_length    = frame_bytes;
      res.declared_length = captured ? num_mag : 16'd0;
      if (!captured || num_mag == 0) res.status = ST_MISSING;
      else if (num_neg) res.status = ST_MISMATCH;
      else if (num_mag == frame_bytes) res.status = ST_OK;
      else res.status = ST_MISMATCH;
      clear_frame();
      return 1'b1;
    end
    for (int i = 0; i < p + 1 - q; i++) commit_byte(i < p ? DELIM[i] : c);
    delim_seen = q[1:0];
    res = '{16'd0, 16'd0, ST_OK};
    return 1'b0;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    stim_q.push_back('{b, 1'b0, '{16'd0, 16'd0, ST_OK}});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_number(int unsigned v);
    push_text($sformatf("%0d", v));
  endfunction

  function automatic void push_delim();
    for (int i = 0; i < 4; i++) push_byte(DELIM[i]);
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CHAR_COMMA || c == CHAR_COLON);
    return c;
  endfunction

  function automatic logic [7:0] rand_sep();
    return $urandom_range(0, 1) ? CHAR_COMMA : CHAR_COLON;
  endfunction

  function automatic logic [7:0] rand_space();
    return ($urandom_range(0, 2) == 0) ? CHAR_SPACE : 8'(CHAR_TAB + $urandom_range(0, 3));
  endfunction

  function automatic void gen_keyed_frame(bit match);
    int start;
    int target;
    start = stim_q.size();
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(0, 4)) push_byte(rand_text_char());
      push_byte(rand_sep());
    end
    if ($urandom_range(0, 7) == 0) push_byte(CHAR_M);
    push_text(KEY_TEXT);
    repeat ($urandom_range(1, 2)) push_byte(rand_sep());
    repeat ($urandom_range(0, 2)) push_byte(rand_space());
    case ($urandom_range(0, 7))
      0: push_byte(CHAR_MINUS);
      1: push_byte(CHAR_PLUS);
      default: ;
    endcase
    if (match) begin
      target = stim_q.size() - start + 6 + $urandom_range(0, 60);
      push_number(target);
      push_byte(rand_sep());
      while (stim_q.size() - start < target) push_byte(rand_text_char());
    end else begin
      case ($urandom_range(0, 3))
        0: push_number($urandom_range(0, 9));
        1: push_number($urandom_range(0, 99999));
        2: push_number($urandom_range(0, 200));
        default: ;
      endcase
      repeat ($urandom_range(0, 30)) begin
        if ($urandom_range(0, 15) == 0) begin
          push_byte(CHAR_CR);
          push_byte(CHAR_LF);
          if ($urandom_range(0, 1)) push_byte(CHAR_CR);
        end else begin
          push_byte(rand_text_char());
        end
      end
    end
    push_delim();
  endfunction

  function automatic void gen_noise_frame();
    repeat ($urandom_range(0, 40)) push_byte(8'($urandom_range(0, 255)));
    push_delim();
  endfunction

  function automatic void gen_keyless_frame();
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 1)) push_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
        else push_byte(rand_text_char());
      end
      push_byte(rand_sep());
    end
    push_delim();
  endfunction

  function automatic void build_stimulus();
    logic [7:0] b;
    int         rand_start;
    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int i = 0; i < dir_table[r].text.len(); i++) begin
        b = dir_table[r].text[i];
        push_byte(b == NUL_MARK ? CHAR_NUL : b);
      end
      push_delim();
      stim_q[stim_q.size() - 1].typed = dir_table[r].typed;
      stim_q[stim_q.size() - 1].res   = '{dir_table[r].flen, dir_table[r].dlen,
                                           dir_table[r].st};
    end
    rand_start = stim_q.size();
    while (stim_q.size() - rand_start < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gen_keyed_frame(1'b1);
        4, 5, 6:    gen_keyed_frame(1'b0);
        7, 8:       gen_noise_frame();
        default:    gen_keyless_frame();
      endcase
    end
  endfunction

  always @(posedge clk) begin : drive_bytes
    frame_rec_t got;
    bit         hold;
    hold = 1'b0;
    if (running) begin
      if (in_push && !in_full) begin
        if (track_frame_byte(in_data_byte, got))
          pending_frames.push_back(stim_q[sent].typed ? stim_q[sent].res : got);
        sent++;
      end else if (in_push) begin
        hold = 1'b1;
      end
      if (!hold) begin
        if (sent == stim_q.size()) begin
          in_push <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_push <= 1'b0;
        end else begin
          in_push      <= 1'b1;
          in_data_byte <= stim_q[sent].data;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              3, 4, 5: gap_left = $urandom_range(1, 4);
              6:       gap_left = $urandom_range(5, 12);
              default: gap_left = $urandom_range(13, 40);
            endcase
          end
        end
      end
    end
  end

  always @(posedge clk) begin : check_frames
    frame_rec_t want;
    if (running && out_pop && !out_empty) begin
      if (pending_frames.size() == 0) begin
        $error("frame result with none pending: length %0d declared %0d status %0d",
               out_frame_length, out_declared_length, out_frame_status);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        if (out_frame_length !== want.frame_length) begin
          $error("frame_length expected %0d, got %0d", want.frame_length, out_frame_length);
          mismatches++;
        end
        if (out_declared_length !== want.declared_length) begin
          $error("declared_length expected %0d, got %0d", want.declared_length,
                 out_declared_length);
          mismatches++;
        end
        if (out_frame_status !== want.status) begin
          $error("frame_status expected %0d, got %0d", want.status, out_frame_status);
          mismatches++;
        end
      end
    end
    if (running) begin
      if (pop_hold == 0) begin
        pop_hold = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       pop_pattern <= 16'hFFFF;
          1:       pop_pattern <= 16'h0001 << $urandom_range(0, 15);
          default: pop_pattern <= 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
        endcase
      end else begin
        pop_hold--;
        pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
      end
      out_pop <= pop_pattern[0];
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    clear_frame();
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n   <= 1'b1;
    running <= 1'b1;
    while (sent != stim_q.size()) @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
